### hw/rtl/tsmc_pkg.sv
`default_nettype none
package tsmc_pkg;

  // Frame and window limits
  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int MAX_TOLERANCE = 15;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 8;
  localparam int ALPHA_W    = 16;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 4;
  localparam int CLASS_W    = 3;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Mask row memory geometry: one row of pixels per word
  localparam int ROW_AW = $clog2(MAX_HEIGHT);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(65536);

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // Pixel classes
  localparam logic [CLASS_W-1:0] CLS_NONE      = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_MUTUAL    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_TOL_REF   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_MISSING   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_TOL_CAND  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_EXCESS    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_RADIUS   = 2'd3;

  // Search window: row bounds and column select
  typedef struct packed {
    logic [COORD_W-1:0]   y0;
    logic [COORD_W-1:0]   y1;
    logic [MAX_WIDTH-1:0] cols;
  } win_t;

endpackage
`default_nettype wire

### hw/rtl/tolerant_support_mask_compare.sv
// Load inside the frame passes the load state, busy, with no done; classify outside the frame
// gives done in the cycle after start, a mutual or empty pixel gives done from the fetch state,
// a one-sided pixel scans N window rows (N up to 2*tolerance_radius+1, 31 at most), one mask row
// read per cycle, until a hit or the last row. Next item accepted in the cycle done is high.
// Reset: synchronous, sets state, done, counters and config registers to defaults; mask memories
// keep contents and are undefined until loaded. The receiver cannot stall results.
`default_nettype none
module tolerant_support_mask_compare (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tsmc_pkg::CMD_W-1:0]      cmd,
  input  wire logic [tsmc_pkg::COORD_W-1:0]    pixel_x,
  input  wire logic [tsmc_pkg::COORD_W-1:0]    pixel_y,
  input  wire logic [tsmc_pkg::ALPHA_W-1:0]    ref_alpha,
  input  wire logic [tsmc_pkg::ALPHA_W-1:0]    cand_alpha,
  output logic                                 done,
  output logic      [tsmc_pkg::CLASS_W-1:0]    pixel_class,
  output logic      [tsmc_pkg::CNT_W-1:0]      missing_total,
  output logic      [tsmc_pkg::CNT_W-1:0]      excess_total,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tsmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsmc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_SCAN
  } state_t;

  state_t state;

  logic [DIM_W-1:0]   cfg_width, cfg_height, w_eff, h_eff;
  logic [ALPHA_W-1:0] cfg_thresh;
  logic [RAD_W-1:0]   cfg_radius;

  logic [COORD_W-1:0] px, py;
  logic               ref_bit, cand_bit, search_ref;
  logic [ROW_AW-1:0]  cur_row, rd_addr;
  win_t               win, win_c;
  logic [CNT_W-1:0]   miss_cnt, exc_cnt;

  logic                 inside_in, hit, last_row, mem_we;
  logic [MAX_WIDTH-1:0] ref_q, cand_q, ref_wr, cand_wr, scan_q;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIM_W'(256);
      cfg_height <= DIM_W'(256);
      cfg_thresh <= ALPHA_W'(32768);
      cfg_radius <= RAD_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_height <= cfg_data[DIM_W-1:0];
        REG_THRESHOLD:    cfg_thresh <= cfg_data[ALPHA_W-1:0];
        REG_TOL_RADIUS:   cfg_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and bounds check
  always_comb begin
    w_eff     = (cfg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_width;
    h_eff     = (cfg_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_height;
    inside_in = ({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff);
  end

  tsmc_win u_win (
    .x      (px),
    .y      (py),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .radius (cfg_radius),
    .win    (win_c)
  );

  // Row read address per phase
  always_comb begin
    unique case (state)
      ST_IDLE:  rd_addr = pixel_y;
      ST_FETCH: rd_addr = win_c.y0;
      ST_SCAN:  rd_addr = cur_row + 1'b1;
      default:  rd_addr = py;
    endcase
  end

  // Merge the loaded bit into the fetched row
  always_comb begin
    mem_we      = (state == ST_LOAD);
    ref_wr      = ref_q;
    cand_wr     = cand_q;
    ref_wr[px]  = ref_bit;
    cand_wr[px] = cand_bit;
  end

  tsmc_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_ref_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (py),
    .wdata (ref_wr),
    .raddr (rd_addr),
    .rdata (ref_q)
  );

  tsmc_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_cand_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (py),
    .wdata (cand_wr),
    .raddr (rd_addr),
    .rdata (cand_q)
  );

  // Window hit on the row now out of memory
  always_comb begin
    scan_q   = search_ref ? ref_q : cand_q;
    hit      = |(scan_q & win.cols);
    last_row = (cur_row == win.y1);
  end

  assign busy          = (state != ST_IDLE);
  assign missing_total = miss_cnt;
  assign excess_total  = exc_cnt;

  // Command sequencer, counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      miss_cnt <= '0;
      exc_cnt  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            px       <= pixel_x;
            py       <= pixel_y;
            ref_bit  <= (ref_alpha >= cfg_thresh);
            cand_bit <= (cand_alpha >= cfg_thresh);
            case (cmd)
              CMD_LOAD: begin
                if (inside_in) begin
                  state <= ST_LOAD;
                end
              end
              CMD_CLASSIFY: begin
                if (inside_in) begin
                  state <= ST_FETCH;
                end else begin
                  done        <= 1'b1;
                  pixel_class <= CLS_NONE;
                end
              end
              CMD_CLEAR: begin
                miss_cnt <= '0;
                exc_cnt  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          state <= ST_IDLE;
        end
        ST_FETCH: begin
          win        <= win_c;
          cur_row    <= win_c.y0;
          search_ref <= !ref_q[px];
          if (ref_q[px] == cand_q[px]) begin
            done        <= 1'b1;
            pixel_class <= ref_q[px] ? CLS_MUTUAL : CLS_NONE;
            state       <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit || last_row) begin
            done  <= 1'b1;
            state <= ST_IDLE;
            if (hit) begin
              pixel_class <= search_ref ? CLS_TOL_CAND : CLS_TOL_REF;
            end else if (search_ref) begin
              pixel_class <= CLS_EXCESS;
              if (exc_cnt < CNT_MAX) begin
                exc_cnt <= exc_cnt + 1'b1;
              end
            end else begin
              pixel_class <= CLS_MISSING;
              if (miss_cnt < CNT_MAX) begin
                miss_cnt <= miss_cnt + 1'b1;
              end
            end
          end else begin
            cur_row <= cur_row + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_scan_rows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cur_row >= win.y0 && cur_row <= win.y1))
    else $error("scan row outside window");

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    (miss_cnt <= CNT_MAX) && (exc_cnt <= CNT_MAX))
    else $error("counter above saturation value");

  a_miss_step: assert property (@(posedge clk) disable iff (rst)
    (miss_cnt != $past(miss_cnt)) |->
      (miss_cnt == '0 || (done && pixel_class == CLS_MISSING)))
    else $error("missing counter moved without a missing result");
`endif

endmodule
`default_nettype wire

### hw/rtl/tsmc_ram.sv
`default_nettype none
module tsmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/tsmc_win.sv
`default_nettype none
module tsmc_win (
  input  wire logic [tsmc_pkg::COORD_W-1:0] x,
  input  wire logic [tsmc_pkg::COORD_W-1:0] y,
  input  wire logic [tsmc_pkg::DIM_W-1:0]   w_eff,
  input  wire logic [tsmc_pkg::DIM_W-1:0]   h_eff,
  input  wire logic [tsmc_pkg::RAD_W-1:0]   radius,
  output tsmc_pkg::win_t                    win
);
  import tsmc_pkg::*;

  logic [RAD_W-1:0] t;
  logic [DIM_W-1:0] te, xe, ye, x0, x1, y0, y1, x_sum, y_sum, x_max, y_max;

  // Clip the square window at the frame edges
  always_comb begin
    t     = (radius > RAD_W'(MAX_TOLERANCE)) ? RAD_W'(MAX_TOLERANCE) : radius;
    te    = DIM_W'(t);
    xe    = {1'b0, x};
    ye    = {1'b0, y};
    x0    = (xe > te) ? xe - te : '0;
    y0    = (ye > te) ? ye - te : '0;
    x_sum = xe + te;
    y_sum = ye + te;
    x_max = w_eff - 1'b1;
    y_max = h_eff - 1'b1;
    x1    = (x_sum < x_max) ? x_sum : x_max;
    y1    = (y_sum < y_max) ? y_sum : y_max;

    win.y0   = y0[COORD_W-1:0];
    win.y1   = y1[COORD_W-1:0];
    win.cols = ({MAX_WIDTH{1'b1}} << x0)
             & ({MAX_WIDTH{1'b1}} >> (DIM_W'(MAX_WIDTH - 1) - x1));
  end

endmodule
`default_nettype wire
